// ===== src/gai_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gai_pkg
// Shared widths, constants and types of the gyro angle integrator.
// ============================================================================
package gai_pkg;

    // Number of bias calibration samples taken after reset
    localparam int CALIB_COUNT = 800;

    localparam int N_AXES    = 3;
    localparam int RAW_W     = 16;
    localparam int DT_W      = 16;
    localparam int RANGE_W   = 2;
    localparam int RATE_W    = 29;
    localparam int TOTAL_W   = 64;
    localparam int TURN_W    = 32;
    localparam int WRAP_W    = 33;
    localparam int INC_W     = 34;
    localparam int ANG_W     = 35;
    localparam int BIAS_W    = 25;
    localparam int DIFF_W    = 26;
    localparam int DMAG_W    = 25;
    localparam int PROD_W    = 44;
    localparam int SUM_W     = RAW_W + $clog2(CALIB_COUNT);
    localparam int CAL_CNT_W = $clog2(CALIB_COUNT + 1);

    // Stream payload widths
    localparam int IN_TDATA_W   = 3 * RAW_W + DT_W;
    localparam int OUT_FIELDS_W = N_AXES * (RATE_W + TOTAL_W + TURN_W);
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // APB register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_GYRO_RANGE = 1'b0;

    // Iterative divider: 4 quotient bits per cycle over a 56-bit dividend
    localparam int NUM_W       = 56;
    localparam int DEN_W       = 21;
    localparam int DIV_QB      = 4;
    localparam int DIV_STEPS   = NUM_W / DIV_QB;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    // Divisors (the divider sees twice the divisor for round to nearest)
    localparam logic [DEN_W-1:0] CAL_DEN  = DEN_W'(2 * CALIB_COUNT);
    localparam logic [DEN_W-1:0] INC_DEN  = DEN_W'(2000000);
    localparam logic [DEN_W-1:0] INC_HALF = DEN_W'(1000000);

    // Rate scale: deg/s Q.16 from Q16.8 raw over tenths of LSB per dps
    localparam logic [11:0] RATE_SCALE = 12'd2560;

    // Sensitivity in tenths of LSB per dps, by full-scale code
    localparam logic [11:0] SENS_TENTHS [4] = '{12'd1310, 12'd655, 12'd328, 12'd164};

    // Angle constants in Q.24 degrees
    localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180) <<< 24;
    localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(360) <<< 24;

    // Per-cycle commands from the sequencer to every lane
    typedef struct packed {
        logic load;
        logic cal_add;
        logic bias_go;
        logic bias_wr;
        logic prep;
        logic rate_go;
        logic rate_wr;
        logic mul;
        logic inc_go;
        logic inc_wr;
        logic upd;
    } t_lane_ctl;

    // Per-axis result fields
    typedef struct packed {
        logic signed [TURN_W-1:0]  turns;
        logic signed [TOTAL_W-1:0] total;
        logic signed [RATE_W-1:0]  rate;
    } t_lane_res;

endpackage

// ===== src/gyro_angle_integrator_turn_counter_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gyro_angle_integrator_turn_counter_top
// Three-axis gyro rate integration with bias calibration and turn counting.
// ============================================================================
//
//  Channel   Direction  Handshake                   Payload
//  s_axis    in         tvalid / tready             tdata: raw_x, raw_y, raw_z, dt_us
//  m_axis    out        tvalid / tready             tdata: rates, totals, turns
//                                                   tuser: calibrating
//  apb       in/out     psel, penable, pready       gyro_range at byte address 0
//
//  A calibration sample runs no division; the one that completes calibration
//  runs the bias division in every axis lane.
//  A normal sample runs two divisions (four quotient bits per cycle) in every
//  axis lane between accept and result.
//  One sample is in work at a time; a finished result waits in the output
//  register while the next sample is accepted. Reset is synchronous and
//  clears calibration, angles and turn counts; no clearing pass follows.
// ============================================================================
module gyro_angle_integrator_turn_counter_top import gai_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // raw_x[15:0], raw_y[31:16], raw_z[47:32], dt_us[63:48]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // rate_x, rate_y, rate_z (29 each), total_x, total_y, total_z (64 each),
    // turns_x, turns_y, turns_z (32 each), one zero pad bit
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // calibrating
    output logic                   o_m_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BIAS_GO,
        S_BIAS_WAIT,
        S_BIAS_WR,
        S_PREP,
        S_RATE_GO,
        S_RATE_WAIT,
        S_RATE_WR,
        S_MUL,
        S_INC_GO,
        S_INC_WAIT,
        S_INC_WR,
        S_UPD,
        S_OUT
    } t_state;

    t_state                 r_state;
    logic [CAL_CNT_W-1:0]   r_cal_cnt;
    logic                   r_cal_item;
    logic [DT_W-1:0]        r_dt;
    logic [RANGE_W-1:0]     r_range;
    logic                   r_out_valid;
    logic                   r_out_user;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                   w_in_acc;
    logic                   w_calibrating;
    logic                   w_cfg_wr;
    logic                   w_busy;
    logic [N_AXES-1:0]      w_lane_busy;
    t_lane_ctl              w_ctl;
    t_lane_res              w_res [N_AXES];
    logic [OUT_FIELDS_W-1:0] w_pack;

    assign w_in_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_calibrating = (r_cal_cnt < CAL_CNT_W'(CALIB_COUNT));
    assign w_busy        = |w_lane_busy;

    // Configuration register
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_GYRO_RANGE) ? APB_DW'(r_range) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= '0;
        end else if (w_cfg_wr && paddr[2] == REG_GYRO_RANGE) begin
            r_range <= pwdata[RANGE_W-1:0];
        end
    end

    // Decode lane commands from the sequencer state
    always_comb begin
        w_ctl         = '0;
        w_ctl.load    = w_in_acc;
        w_ctl.cal_add = w_in_acc && w_calibrating;
        case (r_state)
            S_BIAS_GO:  w_ctl.bias_go = 1'b1;
            S_BIAS_WR:  w_ctl.bias_wr = 1'b1;
            S_PREP:     w_ctl.prep    = 1'b1;
            S_RATE_GO:  w_ctl.rate_go = 1'b1;
            S_RATE_WR:  w_ctl.rate_wr = 1'b1;
            S_MUL:      w_ctl.mul     = 1'b1;
            S_INC_GO:   w_ctl.inc_go  = 1'b1;
            S_INC_WR:   w_ctl.inc_wr  = 1'b1;
            S_UPD:      w_ctl.upd     = 1'b1;
            default:    ;
        endcase
    end

    // Axis lanes
    for (genvar g = 0; g < N_AXES; g++) begin : g_lane
        gai_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_raw   (signed'(i_s_axis_tdata[g*RAW_W +: RAW_W])),
            .i_dt    (r_dt),
            .i_range (r_range),
            .o_busy  (w_lane_busy[g]),
            .o_res   (w_res[g])
        );
    end

    // Merge lane results into the output word
    assign w_pack = {w_res[2].turns, w_res[1].turns, w_res[0].turns,
                     w_res[2].total, w_res[1].total, w_res[0].total,
                     w_res[2].rate,  w_res[1].rate,  w_res[0].rate};

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cal_cnt   <= '0;
            r_cal_item  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_user  <= 1'b0;
            r_out_data  <= '0;
            r_dt        <= '0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_dt <= i_s_axis_tdata[3*RAW_W +: DT_W];
                        if (w_calibrating) begin
                            r_cal_item <= 1'b1;
                            r_cal_cnt  <= r_cal_cnt + 1'b1;
                            if (r_cal_cnt == CAL_CNT_W'(CALIB_COUNT - 1)) begin
                                r_state <= S_BIAS_GO;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_cal_item <= 1'b0;
                            r_state    <= S_PREP;
                        end
                    end
                end
                S_BIAS_GO:   r_state <= S_BIAS_WAIT;
                S_BIAS_WAIT: if (!w_busy) r_state <= S_BIAS_WR;
                S_BIAS_WR:   r_state <= S_OUT;
                S_PREP:      r_state <= S_RATE_GO;
                S_RATE_GO:   r_state <= S_RATE_WAIT;
                S_RATE_WAIT: if (!w_busy) r_state <= S_RATE_WR;
                S_RATE_WR:   r_state <= S_MUL;
                S_MUL:       r_state <= S_INC_GO;
                S_INC_GO:    r_state <= S_INC_WAIT;
                S_INC_WAIT:  if (!w_busy) r_state <= S_INC_WR;
                S_INC_WR:    r_state <= S_UPD;
                S_UPD:       r_state <= S_OUT;
                S_OUT: begin
                    // Load once the previous result has been taken
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_cal_item;
                        r_out_data  <= r_cal_item ? '0 : OUT_TDATA_W'(w_pack);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== src/gai_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gai_div
// Unsigned restoring divider, four quotient bits per cycle.
// ============================================================================
module gai_div import gai_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);

    logic [NUM_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic [NUM_W-1:0]     n_num;
    logic [DEN_W-1:0]     n_rem;

    // Retire four dividend bits: shift in, compare, subtract
    always_comb begin
        logic [DEN_W-1:0] v_rem;
        logic [NUM_W-1:0] v_num;
        logic [DEN_W:0]   v_cand;
        v_rem  = r_rem;
        v_num  = r_num;
        v_cand = '0;
        for (int k = 0; k < DIV_QB; k++) begin
            v_cand = {v_rem, v_num[NUM_W-1]};
            v_num  = {v_num[NUM_W-2:0], 1'b0};
            if (v_cand >= {1'b0, r_den}) begin
                v_rem    = DEN_W'(v_cand - {1'b0, r_den});
                v_num[0] = 1'b1;
            end else begin
                v_rem = v_cand[DEN_W-1:0];
            end
        end
        n_rem = v_rem;
        n_num = v_num;
    end

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Dividend/quotient shift register and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;

endmodule

// ===== src/gai_lane.sv =====
`timescale 1ns / 1ps
// ============================================================================
// gai_lane
// One axis: bias calibration, rate scaling, angle integration, turn count.
// ============================================================================
module gai_lane import gai_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic signed [RAW_W-1:0]  i_raw,
    input  logic [DT_W-1:0]          i_dt,
    input  logic [RANGE_W-1:0]       i_range,
    output logic                     o_busy,
    output t_lane_res                o_res
);

    // Axis state
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [BIAS_W-1:0]  r_bias;
    logic signed [TOTAL_W-1:0] r_total;
    logic signed [WRAP_W-1:0]  r_wrap;
    logic signed [TURN_W-1:0]  r_turns;

    // Per-sample working registers
    logic signed [RAW_W-1:0]  r_raw;
    logic [PROD_W-1:0]        r_prod;
    logic signed [RATE_W-1:0] r_rate;
    logic signed [INC_W-1:0]  r_inc;

    logic [SUM_W-1:0]         w_sum_mag;
    logic signed [DIFF_W-1:0] w_diff;
    logic [DMAG_W-1:0]        w_diff_mag;
    logic [RATE_W-1:0]        w_rate_mag;
    logic [11:0]              w_s10;
    logic                     w_div_start;
    logic [NUM_W-1:0]         w_div_num;
    logic [DEN_W-1:0]         w_div_den;
    logic [NUM_W-1:0]         w_quo;
    logic signed [BIAS_W-1:0] w_q_bias;
    logic signed [RATE_W-1:0] w_q_rate;
    logic signed [INC_W-1:0]  w_q_inc;

    logic signed [ANG_W-1:0]   w_inc;
    logic signed [ANG_W-1:0]   w_wsum;
    logic signed [ANG_W-1:0]   w_wnew;
    logic signed [ANG_W-1:0]   w_d;
    logic                      w_wrap_sub;
    logic                      w_wrap_add;
    logic                      w_turn_up;
    logic                      w_turn_dn;
    logic signed [TOTAL_W:0]   w_tsum;
    logic signed [TOTAL_W-1:0] w_total;

    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

    // Magnitudes and divisor selection
    assign w_sum_mag  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_diff     = (DIFF_W'(r_raw) <<< 8) - DIFF_W'(r_bias);
    assign w_diff_mag = w_diff[DIFF_W-1] ? DMAG_W'(-w_diff) : DMAG_W'(w_diff);
    assign w_rate_mag = r_rate[RATE_W-1] ? RATE_W'(-r_rate) : RATE_W'(r_rate);
    assign w_s10      = SENS_TENTHS[i_range];

    // Feed the divider with 2|n| + d over 2d
    assign w_div_start = i_ctl.bias_go | i_ctl.rate_go | i_ctl.inc_go;
    always_comb begin
        if (i_ctl.bias_go) begin
            w_div_num = NUM_W'({w_sum_mag, 9'b0}) + NUM_W'(CALIB_COUNT);
            w_div_den = CAL_DEN;
        end else if (i_ctl.rate_go) begin
            w_div_num = NUM_W'({r_prod, 1'b0}) + NUM_W'(w_s10);
            w_div_den = DEN_W'({w_s10, 1'b0});
        end else begin
            w_div_num = NUM_W'({r_prod, 9'b0}) + NUM_W'(INC_HALF);
            w_div_den = INC_DEN;
        end
    end

    gai_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (o_busy),
        .o_quo   (w_quo)
    );

    assign w_q_bias = signed'(w_quo[BIAS_W-1:0]);
    assign w_q_rate = signed'(w_quo[RATE_W-1:0]);
    assign w_q_inc  = signed'(w_quo[INC_W-1:0]);

    // Wrap the angle and classify the jump
    assign w_inc      = ANG_W'(r_inc);
    assign w_wsum     = ANG_W'(r_wrap) + w_inc;
    assign w_wrap_sub = (w_wsum >= HALF_TURN);
    assign w_wrap_add = (w_wsum < -HALF_TURN);
    always_comb begin
        if (w_wrap_sub) begin
            w_wnew = w_wsum - FULL_TURN;
            w_d    = w_inc - FULL_TURN;
        end else if (w_wrap_add) begin
            w_wnew = w_wsum + FULL_TURN;
            w_d    = w_inc + FULL_TURN;
        end else begin
            w_wnew = w_wsum;
            w_d    = w_inc;
        end
    end
    assign w_turn_up = (w_d < -HALF_TURN);
    assign w_turn_dn = (w_d > HALF_TURN);

    // Saturating total
    assign w_tsum = (TOTAL_W+1)'(r_total) + (TOTAL_W+1)'(r_inc);
    always_comb begin
        if (w_tsum[TOTAL_W] != w_tsum[TOTAL_W-1]) begin
            w_total = w_tsum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}}
                                      : {1'b0, {(TOTAL_W-1){1'b1}}};
        end else begin
            w_total = w_tsum[TOTAL_W-1:0];
        end
    end

    // Axis state: calibration sum, bias, angles and turns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_bias  <= '0;
            r_total <= '0;
            r_wrap  <= '0;
            r_turns <= '0;
        end else begin
            if (i_ctl.cal_add) begin
                r_sum <= r_sum + SUM_W'(i_raw);
            end
            if (i_ctl.bias_wr) begin
                r_bias <= r_sum[SUM_W-1] ? -w_q_bias : w_q_bias;
            end
            if (i_ctl.upd) begin
                r_total <= w_total;
                r_wrap  <= WRAP_W'(w_wnew);
                if (w_turn_up && r_turns != TURN_MAX) begin
                    r_turns <= r_turns + 1'b1;
                end else if (w_turn_dn && r_turns != TURN_MIN) begin
                    r_turns <= r_turns - 1'b1;
                end
            end
        end
    end

    // Sample working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_raw <= i_raw;
        end
        if (i_ctl.prep) begin
            r_prod <= PROD_W'(37'(w_diff_mag) * 37'(RATE_SCALE));
        end
        if (i_ctl.mul) begin
            r_prod <= PROD_W'(45'(w_rate_mag) * 45'(i_dt));
        end
        if (i_ctl.rate_wr) begin
            r_rate <= w_diff[DIFF_W-1] ? -w_q_rate : w_q_rate;
        end
        if (i_ctl.inc_wr) begin
            r_inc <= r_rate[RATE_W-1] ? -w_q_inc : w_q_inc;
        end
    end

    assign o_res.rate  = r_rate;
    assign o_res.total = r_total;
    assign o_res.turns = r_turns;

endmodule
